### rtl/core/bptc_pkg.sv
// Shared types, codes and helper functions for the buffer pool tag cache.
package bptc_pkg;

	localparam int LFSR_WIDTH = 16;
	localparam int LEN_WIDTH  = 21;
	localparam int SIZE_WIDTH = 5;
	localparam int SLOT_WIDTH = 3;
	localparam int OUT_HANDLE_WIDTH = 32;
	localparam logic [LFSR_WIDTH-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_WIDTH-1:0] LFSR_SEED_DEFAULT = 16'd1;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_INSERT  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic mod_start;
		logic mod_step;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_evict;
		logic mod_last;
	} sts_t;

	// Galois step, taps x^16+x^14+x^13+x^11+1
	function automatic logic [LFSR_WIDTH-1:0] lfsr_next(input logic [LFSR_WIDTH-1:0] v);
		logic [LFSR_WIDTH-1:0] s;
		s = {1'b0, v[LFSR_WIDTH-1:1]};
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	// Round a length up to a power of two and return its log2
	function automatic logic [SIZE_WIDTH-1:0] size_log2(input logic [LEN_WIDTH-1:0] len);
		logic [LEN_WIDTH-1:0]  v;
		logic [SIZE_WIDTH-1:0] k;
		k = '0;
		if (len > LEN_WIDTH'(1)) begin
			v = len - LEN_WIDTH'(1);
			for (int i = 0; i < LEN_WIDTH; i++) begin
				if (v[i]) begin
					k = SIZE_WIDTH'(i + 1);
				end
			end
		end
		return k;
	endfunction

endpackage

### rtl/core/bptc_ctrl.sv
// Controller state machine: sequences accept, eviction pick and result commit.
module bptc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  bptc_pkg::sts_t  sts,
	output bptc_pkg::cmd_t  cmd
);
	import bptc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_MOD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.need_evict) begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_commit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result committed over an untaken result");

	a_mod_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) && sts.mod_last |=> (state_q == ST_FIN))
		else $error("remainder finished but no commit state followed");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

### rtl/core/bptc_dpath.sv
// Datapath: line table, match logic, LFSR and reciprocal victim remainder.
module bptc_dpath #(
	parameter int LINES        = 8,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bptc_pkg::cmd_t                         cmd,
	output bptc_pkg::sts_t                         sts,
	input  logic                                   cfg_wr_en,
	input  logic [bptc_pkg::LFSR_WIDTH-1:0]        cfg_wr_data,
	input  logic [1:0]                             op,
	input  logic [bptc_pkg::LEN_WIDTH-1:0]         req_len,
	input  logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0]  handle,
	output logic                                   hit,
	output logic [bptc_pkg::SLOT_WIDTH-1:0]        slot,
	output logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0]  out_handle,
	output logic                                   evicted,
	output logic                                   not_cached
);
	import bptc_pkg::*;

	localparam int IW = $clog2(LINES);
	localparam int OW = OUT_HANDLE_WIDTH;
	// value mod LINES as value - LINES * ((value * RECIP) >> RECIP_SHIFT), exact for 16 bits
	localparam int RECIP_SHIFT = LFSR_WIDTH + IW;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + LINES - 1) / LINES;
	localparam int PW          = 2 * LFSR_WIDTH + IW + 1;

	// captured request
	logic [1:0]              op_q;
	logic [LEN_WIDTH-1:0]    len_q;
	logic [HANDLE_WIDTH-1:0] h_q;

	// line table
	logic [LINES-1:0]        present_q;
	logic [LINES-1:0]        busy_q;
	logic [HANDLE_WIDTH-1:0] line_handle_q [LINES];
	logic [SIZE_WIDTH-1:0]   line_size_q   [LINES];

	// replacement
	logic [LFSR_WIDTH-1:0]   lfsr_q;
	logic [LFSR_WIDTH-1:0]   div_q;
	logic [LFSR_WIDTH-1:0]   quo_q;
	logic [IW-1:0]           rem_q;
	logic                    phase_q;

	// results
	logic                    hit_q;
	logic [SLOT_WIDTH-1:0]   slot_q;
	logic [OW-1:0]           out_handle_q;
	logic                    evicted_q;
	logic                    not_cached_q;

	logic [SIZE_WIDTH-1:0]   req_size;
	logic [LINES-1:0]        look_m, rel_m, absent_m;
	logic [IW-1:0]           look_idx, rel_idx, absent_idx, pick_idx;
	logic                    all_present;
	logic [PW-1:0]           prod;
	logic [LFSR_WIDTH-1:0]   rem_full;
	logic [HANDLE_WIDTH+OW-1:0] h_ext;
	logic [HANDLE_WIDTH+OW-1:0] rd_ext;
	logic [IW+SLOT_WIDTH-1:0]   slot_ext;
	logic [IW-1:0]           res_idx;

	assign req_size    = size_log2(len_q);
	assign all_present = &present_q;
	assign h_ext       = {{HANDLE_WIDTH{1'b0}}, handle};

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			look_m[i]   = present_q[i] && !busy_q[i] && (line_size_q[i] == req_size);
			rel_m[i]    = present_q[i] && (line_handle_q[i] == h_q);
			absent_m[i] = !present_q[i];
		end
	end

	// lowest set index wins
	always_comb begin
		look_idx   = '0;
		rel_idx    = '0;
		absent_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (look_m[i]) begin
				look_idx = IW'(i);
			end
			if (rel_m[i]) begin
				rel_idx = IW'(i);
			end
			if (absent_m[i]) begin
				absent_idx = IW'(i);
			end
		end
	end

	assign pick_idx = all_present ? rem_q : absent_idx;

	always_comb begin
		case (op_t'(op_q))
			OP_LOOKUP:  res_idx = look_idx;
			OP_INSERT:  res_idx = pick_idx;
			OP_RELEASE: res_idx = rel_idx;
			default:    res_idx = '0;
		endcase
	end

	assign rd_ext   = {{OW{1'b0}}, line_handle_q[res_idx]};
	assign slot_ext = {{SLOT_WIDTH{1'b0}}, res_idx};

	assign prod     = PW'(div_q) * PW'(RECIP);
	assign rem_full = div_q - quo_q * LFSR_WIDTH'(LINES);

	assign sts.need_evict = (op_t'(op_q) == OP_INSERT) && all_present;
	assign sts.mod_last   = phase_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			len_q <= req_len;
			h_q   <= h_ext[HANDLE_WIDTH-1:0];
		end
		if (cmd.commit && (op_t'(op_q) == OP_INSERT)) begin
			line_handle_q[pick_idx] <= h_q;
			line_size_q[pick_idx]   <= req_size;
		end
		// quotient first, then remainder
		if (cmd.mod_start) begin
			div_q   <= lfsr_next(lfsr_q);
			phase_q <= 1'b0;
		end else if (cmd.mod_step) begin
			if (!phase_q) begin
				quo_q <= prod[RECIP_SHIFT +: LFSR_WIDTH];
			end else begin
				rem_q <= rem_full[IW-1:0];
			end
			phase_q <= 1'b1;
		end
		if (cmd.commit) begin
			hit_q        <= 1'b0;
			slot_q       <= '0;
			out_handle_q <= '0;
			evicted_q    <= 1'b0;
			not_cached_q <= 1'b0;
			case (op_t'(op_q))
				OP_LOOKUP: begin
					if (|look_m) begin
						hit_q        <= 1'b1;
						slot_q       <= slot_ext[SLOT_WIDTH-1:0];
						out_handle_q <= rd_ext[OW-1:0];
					end
				end
				OP_INSERT: begin
					slot_q <= slot_ext[SLOT_WIDTH-1:0];
					if (all_present) begin
						evicted_q    <= 1'b1;
						out_handle_q <= rd_ext[OW-1:0];
					end
				end
				OP_RELEASE: begin
					if (|rel_m) begin
						hit_q  <= 1'b1;
						slot_q <= slot_ext[SLOT_WIDTH-1:0];
					end else begin
						not_cached_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			busy_q    <= '0;
			lfsr_q    <= LFSR_SEED_DEFAULT;
		end else begin
			if (cfg_wr_en) begin
				lfsr_q <= (cfg_wr_data == '0) ? LFSR_SEED_DEFAULT : cfg_wr_data;
			end else if (cmd.mod_start) begin
				lfsr_q <= lfsr_next(lfsr_q);
			end
			if (cmd.commit) begin
				case (op_t'(op_q))
					OP_LOOKUP: begin
						if (|look_m) begin
							busy_q[look_idx] <= 1'b1;
						end
					end
					OP_INSERT: begin
						present_q[pick_idx] <= 1'b1;
						busy_q[pick_idx]    <= 1'b1;
					end
					OP_RELEASE: begin
						if (|rel_m) begin
							busy_q[rel_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign hit        = hit_q;
	assign slot       = slot_q;
	assign out_handle = out_handle_q;
	assign evicted    = evicted_q;
	assign not_cached = not_cached_q;

	a_busy_needs_present: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & ~present_q) == '0)
		else $error("busy line that is not present");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && sts.need_evict |-> ({1'b0, rem_q} < (IW+1)'(LINES)))
		else $error("victim index out of range");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("replacement LFSR stuck at zero");

endmodule

### rtl/core/buffer_pool_tag_cache.sv
// Top level of the buffer pool tag cache: controller plus datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  in       | in_valid / in_stall     | op, req_len, handle
//  out      | out_valid / out_stall   | hit, slot, out_handle, evicted, not_cached
//  cfg      | cfg_wr_en               | cfg_wr_data (random seed)
//
// An item is accepted, then matched and committed in one pass over all lines.
// An insert into a full table first picks a victim: the LFSR value mod LINES,
// found by a reciprocal multiply and then a multiply-subtract.
// Reset clears the present and busy bits and loads the LFSR with 1; no clearing pass.
// The next item is accepted while a result waits in the output register; a stalled
// output blocks only the commit of the item after it.
module buffer_pool_tag_cache #(
	parameter int LINES        = 8,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [bptc_pkg::LFSR_WIDTH-1:0]        cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             op,
	input  logic [bptc_pkg::LEN_WIDTH-1:0]         req_len,
	input  logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0]  handle,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   hit,
	output logic [bptc_pkg::SLOT_WIDTH-1:0]        slot,
	output logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0]  out_handle,
	output logic                                   evicted,
	output logic                                   not_cached
);
	import bptc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bptc_dpath #(
		.LINES        (LINES),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.req_len     (req_len),
		.handle      (handle),
		.hit         (hit),
		.slot        (slot),
		.out_handle  (out_handle),
		.evicted     (evicted),
		.not_cached  (not_cached)
	);

endmodule

### bench/buffer_pool_tag_cache_checker.sv
// Checker for the buffer pool tag cache: tracks the tag table, predicts each result and compares.
`timescale 1ns / 1ps

module buffer_pool_tag_cache_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bptc_pkg::LFSR_WIDTH-1:0]       cfg_wr_data,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [1:0]                            op,
	input  logic [bptc_pkg::LEN_WIDTH-1:0]        req_len,
	input  logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0] handle,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic                                  hit,
	input  logic [bptc_pkg::SLOT_WIDTH-1:0]       slot,
	input  logic [bptc_pkg::OUT_HANDLE_WIDTH-1:0] out_handle,
	input  logic                                  evicted,
	input  logic                                  not_cached,
	output int                                    mismatches,
	output int                                    outstanding
);
	import bptc_pkg::*;

	localparam int LINES = 8;

	typedef struct packed {
		logic                        hit;
		logic [SLOT_WIDTH-1:0]       slot;
		logic [OUT_HANDLE_WIDTH-1:0] out_handle;
		logic                        evicted;
		logic                        not_cached;
	} table_result_t;

	logic [LINES-1:0]            line_present;
	logic [LINES-1:0]            line_busy;
	logic [OUT_HANDLE_WIDTH-1:0] line_handle [LINES];
	logic [SIZE_WIDTH-1:0]       line_size [LINES];
	logic [LFSR_WIDTH-1:0]       victim_lfsr;
	table_result_t               awaited_results [$];

	function automatic int ceil_log2(input logic [LEN_WIDTH-1:0] len);
		int k;
		k = 0;
		while ((1 << k) < int'(len)) begin
			k++;
		end
		return k;
	endfunction

	// Apply one request to the tracked table and return the result it must produce
	function automatic table_result_t access_table(input op_t kind,
			input logic [LEN_WIDTH-1:0] len, input logic [OUT_HANDLE_WIDTH-1:0] h);
		table_result_t r;
		int            pick;
		logic [SIZE_WIDTH-1:0] sz;
		r = '0;
		pick = -1;
		sz = SIZE_WIDTH'(ceil_log2(len));
		case (kind)
			OP_LOOKUP: begin
				for (int i = 0; i < LINES; i++) begin
					if (pick < 0 && line_present[i] && !line_busy[i] && line_size[i] == sz) begin
						pick = i;
					end
				end
				if (pick >= 0) begin
					line_busy[pick] = 1'b1;
					r.hit = 1'b1;
					r.slot = SLOT_WIDTH'(pick);
					r.out_handle = line_handle[pick];
				end
			end
			OP_INSERT: begin
				for (int i = 0; i < LINES; i++) begin
					if (pick < 0 && !line_present[i]) begin
						pick = i;
					end
				end
				// full table: advance the LFSR, then evict the line it names
				if (pick < 0) begin
					victim_lfsr = {1'b0, victim_lfsr[LFSR_WIDTH-1:1]}
						^ (victim_lfsr[0] ? LFSR_TAPS : '0);
					pick = int'(victim_lfsr % LINES);
					r.evicted = 1'b1;
					r.out_handle = line_handle[pick];
				end
				line_handle[pick] = h;
				line_size[pick] = sz;
				line_present[pick] = 1'b1;
				line_busy[pick] = 1'b1;
				r.slot = SLOT_WIDTH'(pick);
			end
			OP_RELEASE: begin
				r.not_cached = 1'b1;
				for (int i = 0; i < LINES; i++) begin
					if (pick < 0 && line_present[i] && line_handle[i] == h) begin
						pick = i;
					end
				end
				if (pick >= 0) begin
					line_busy[pick] = 1'b0;
					r.hit = 1'b1;
					r.slot = SLOT_WIDTH'(pick);
					r.not_cached = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			line_present = '0;
			line_busy = '0;
			victim_lfsr = LFSR_SEED_DEFAULT;
			mismatches = 0;
			awaited_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing awaited");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("slot", 32'(want.slot), 32'(slot));
					check_field("out_handle", want.out_handle, out_handle);
					check_field("evicted", 32'(want.evicted), 32'(evicted));
					check_field("not_cached", 32'(want.not_cached), 32'(not_cached));
				end
			end
			if (cfg_wr_en) begin
				// a zero seed would lock the LFSR, load 1 instead
				victim_lfsr = (cfg_wr_data == '0) ? LFSR_WIDTH'(1) : cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				awaited_results.push_back(access_table(op_t'(op), req_len, handle));
			end
		end
		outstanding = awaited_results.size();
	end

endmodule

### bench/buffer_pool_tag_cache_tb.sv
// Testbench top for the buffer pool tag cache: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module buffer_pool_tag_cache_tb;
	import bptc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 95;
	localparam int POOL_SIZE      = 16;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	logic [LFSR_WIDTH-1:0]       cfg_wr_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [1:0]                  op = OP_NONE;
	logic [LEN_WIDTH-1:0]        req_len = '0;
	logic [OUT_HANDLE_WIDTH-1:0] handle = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        hit;
	logic [SLOT_WIDTH-1:0]       slot;
	logic [OUT_HANDLE_WIDTH-1:0] out_handle;
	logic                        evicted;
	logic                        not_cached;

	int                          mismatches;
	int                          outstanding;
	int unsigned                 requests_sent = 0;
	int unsigned                 results_taken = 0;
	int unsigned                 idle_cycles = 0;
	bit                          hold_req = 1'b0;
	logic [OUT_HANDLE_WIDTH-1:0] handle_pool [POOL_SIZE];
	logic [LFSR_WIDTH-1:0]       phase_seeds [4];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	buffer_pool_tag_cache DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.req_len    (req_len),
		.handle     (handle),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.slot       (slot),
		.out_handle (out_handle),
		.evicted    (evicted),
		.not_cached (not_cached)
	);

	buffer_pool_tag_cache_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.req_len    (req_len),
		.handle     (handle),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.slot       (slot),
		.out_handle (out_handle),
		.evicted    (evicted),
		.not_cached (not_cached),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			requests_sent <= requests_sent + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_taken <= results_taken + 1;
		end
	end

	// End the run if nothing transfers for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Lengths cluster on a few sizes so lookups find matching lines
	function automatic logic [LEN_WIDTH-1:0] pick_len();
		int exps [7] = '{0, 1, 2, 3, 4, 20, 21};
		int k;
		int lo;
		int hi;
		k = exps[$urandom_range(0, 6)];
		if (k == 0) begin
			return LEN_WIDTH'($urandom_range(0, 1));
		end
		lo = (1 << (k - 1)) + 1;
		hi = (k == LEN_WIDTH) ? (1 << LEN_WIDTH) - 1 : (1 << k);
		return LEN_WIDTH'($urandom_range(hi, lo));
	endfunction

	function automatic logic [OUT_HANDLE_WIDTH-1:0] pick_handle(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct) begin
			return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		return $urandom();
	endfunction

	task automatic send_request(input op_t kind, input logic [LEN_WIDTH-1:0] len,
			input logic [OUT_HANDLE_WIDTH-1:0] h, input int gap);
		op <= kind;
		req_len <= len;
		handle <= h;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every transfer in flight has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_taken != requests_sent) begin
			@(posedge clk);
		end
		repeat (25) @(posedge clk);
	endtask

	task automatic write_seed(input logic [LFSR_WIDTH-1:0] seed);
		cfg_wr_data <= seed;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_request(input int idx);
		int   r;
		int   gap;
		op_t  kind;
		r = $urandom_range(0, 99);
		if (r < 38) begin
			kind = OP_LOOKUP;
		end else if (r < 70) begin
			kind = OP_INSERT;
		end else if (r < 93) begin
			kind = OP_RELEASE;
		end else begin
			kind = OP_NONE;
		end
		// churn the handle pool so inserts keep bringing new handles
		if ($urandom_range(0, 9) == 0) begin
			handle_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
		end
		// back-to-back stretch at the start of every window
		gap = (idx % 60 < 15) ? 0 : pick_gap();
		send_request(kind, pick_len(), pick_handle(kind == OP_RELEASE ? 85 : 65), gap);
	endtask

	// Receiver: random stalls, quiet stretches and one long hold on request
	initial begin
		int stall_left;
		int quiet_left;
		stall_left = 0;
		quiet_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (quiet_left > 0) begin
				quiet_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				quiet_left = $urandom_range(20, 60);
			end else begin
				stall_left = pick_gap();
			end
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			handle_pool[i] = $urandom();
		end
		phase_seeds[0] = 16'hFFFF;
		phase_seeds[1] = 16'h0001;
		phase_seeds[2] = LFSR_WIDTH'($urandom_range(1, 65535));
		phase_seeds[3] = LFSR_WIDTH'($urandom_range(1, 65535));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero seed must load as one
		write_seed('0);
		send_request(OP_LOOKUP, 21'd1, 32'h0000_0000, pick_gap());
		send_request(OP_RELEASE, 21'd1, 32'hDEAD_BEEF, pick_gap());
		send_request(OP_NONE, 21'h1F_FFFF, 32'hFFFF_FFFF, pick_gap());
		send_request(OP_INSERT, 21'd0, 32'hFFFF_FFFF, pick_gap());
		send_request(OP_INSERT, 21'h1F_FFFF, 32'h0000_0000, pick_gap());
		send_request(OP_INSERT, 21'h10_0000, 32'h1234_5678, pick_gap());
		send_request(OP_LOOKUP, 21'd0, 32'h0000_0000, pick_gap());
		send_request(OP_RELEASE, 21'd0, 32'hFFFF_FFFF, pick_gap());
		// release an idle line again
		send_request(OP_RELEASE, 21'd0, 32'hFFFF_FFFF, pick_gap());
		send_request(OP_LOOKUP, 21'd1, 32'h0000_0000, pick_gap());
		send_request(OP_RELEASE, 21'd0, 32'h0000_0000, pick_gap());
		send_request(OP_LOOKUP, 21'h10_0001, 32'h0000_0000, pick_gap());
		send_request(OP_INSERT, 21'h0A_AAAA, 32'hA5A5_A5A5, pick_gap());
		send_request(OP_INSERT, 21'h15_5555, 32'h5A5A_5A5A, pick_gap());
		send_request(OP_INSERT, 21'd3, 32'h0000_0003, pick_gap());
		send_request(OP_INSERT, 21'd4, 32'h8000_0000, pick_gap());
		send_request(OP_INSERT, 21'd5, 32'h7FFF_FFFF, pick_gap());
		// table full from here: inserts evict
		send_request(OP_INSERT, 21'd1, 32'hCAFE_F00D, pick_gap());
		send_request(OP_INSERT, 21'd2, 32'h0BAD_F00D, pick_gap());
		send_request(OP_INSERT, 21'h10_0000, 32'h1234_5678, pick_gap());
		send_request(OP_RELEASE, 21'd0, 32'h1234_5678, pick_gap());
		send_request(OP_LOOKUP, 21'h10_0000, 32'h0000_0000, pick_gap());
		send_request(OP_NONE, 21'd0, 32'h0000_0000, pick_gap());
		drain();

		for (int p = 0; p < 4; p++) begin
			write_seed(phase_seeds[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the output long enough to back up the input
				if (p == 0 && i == 40) begin
					hold_req = 1'b1;
				end
				random_request(i);
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
